// ===== design/sorted_value_list_macros.svh =====
// Assertion macros used by the sorted value list controller.
`ifndef SORTED_VALUE_LIST_MACROS_SVH
`define SORTED_VALUE_LIST_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SVL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold.
`define SVL_ASSERT_NEVER(label, cond, msg) \
  `SVL_ASSERT(label, !(cond), msg)

`endif

// ===== design/svl_pkg.sv =====
// Shared constants, codes and types of the sorted value list.
package svl_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 5;
  localparam int NUM_W    = 6;
  localparam int OUT_BITS = STAT_W + 1 + POS_W + VAL_W + NUM_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP_UP   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP_DOWN = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic             exec;  // run the accepted command, load its result
    logic             emit;  // load one dump result from the cell at idx
    logic             last;
    logic [IDX_W-1:0] idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic                    found;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
    logic [NUM_W-1:0]        element_count;
    logic                    last;
  } res_t;

endpackage

// ===== design/svl_ctrl.sv =====
// Controller: input/output handshake and dump sequencing.
`include "sorted_value_list_macros.svh"

module svl_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [svl_pkg::CMD_W-1:0] command_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  logic [svl_pkg::CNT_W-1:0] count_i,
  output svl_pkg::ctl_cmd_t        cmd_o
);
  import svl_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] dump_cnt_q, dump_cnt_d;
  logic             dump_down_q, dump_down_d;
  logic             out_valid_q, out_valid_d;
  logic             can_load, accept, is_dump;
  logic [CNT_W-1:0] dump_pos;

  assign can_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && can_load;
  assign accept     = in_valid_i && in_ready_o;
  assign is_dump    = (command_i == CMD_DUMP_UP) || (command_i == CMD_DUMP_DOWN);
  assign dump_pos   = dump_down_q ? (count_i - CNT_W'(1) - dump_cnt_q) : dump_cnt_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    dump_cnt_d  = dump_cnt_q;
    dump_down_d = dump_down_q;
    cmd_o.exec  = 1'b0;
    cmd_o.emit  = 1'b0;
    cmd_o.last  = (dump_cnt_q + CNT_W'(1)) == count_i;
    cmd_o.idx   = dump_pos[IDX_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_dump && (count_i != '0)) begin
            state_d     = S_DUMP;
            dump_cnt_d  = '0;
            dump_down_d = (command_i == CMD_DUMP_DOWN);
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      S_DUMP: begin
        if (can_load) begin
          cmd_o.emit = 1'b1;
          dump_cnt_d = dump_cnt_q + CNT_W'(1);
          if (cmd_o.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.exec || cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dump_cnt_q  <= '0;
      dump_down_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dump_cnt_q  <= dump_cnt_d;
      dump_down_q <= dump_down_d;
      out_valid_q <= out_valid_d;
    end
  end

  `SVL_ASSERT(a_dump_nonempty, (state_q == S_DUMP) |-> (count_i != '0), "dump of empty store")
  `SVL_ASSERT(a_dump_in_range, (state_q == S_DUMP) |-> (dump_cnt_q < count_i), "dump overrun")
  `SVL_ASSERT(a_dump_ends, (state_q == S_DUMP && cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE), "dump did not end")
  `SVL_ASSERT_NEVER(a_one_load, cmd_o.exec && cmd_o.emit, "exec and emit together")

endmodule

// ===== design/svl_cells.sv =====
// Datapath: ordered cell array with parallel compare and shift, result register.
module svl_cells (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  svl_pkg::ctl_cmd_t                cmd_i,
  input  logic [svl_pkg::CMD_W-1:0]        command_i,
  input  logic signed [svl_pkg::VAL_W-1:0] operand_i,
  output logic [svl_pkg::CNT_W-1:0]        count_o,
  output svl_pkg::res_t                    res_o
);
  import svl_pkg::*;

  logic signed [VAL_W-1:0] cells_q [DEPTH];
  logic signed [VAL_W-1:0] cells_d [DEPTH];
  logic [CNT_W-1:0]        count_q, count_d;
  res_t                    res_q, exec_res;
  logic [DEPTH-1:0]        lt, eq;
  logic [IDX_W-1:0]        ins_p, eq_p;
  logic                    full, hit;

  assign full = count_q == CNT_W'(DEPTH);
  assign hit  = |eq;

  // Per-cell compares against the operand, limited to occupied cells
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < count_q) && (cells_q[i] < operand_i);
      eq[i] = (CNT_W'(i) < count_q) && (cells_q[i] == operand_i);
    end
  end

  // First cell not below the operand, and first equal cell
  always_comb begin
    ins_p = '0;
    eq_p  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!lt[i]) begin
        ins_p = IDX_W'(i);
      end
      if (eq[i]) begin
        eq_p = IDX_W'(i);
      end
    end
  end

  always_comb begin
    cells_d  = cells_q;
    count_d  = count_q;
    exec_res = '0;
    exec_res.last = 1'b1;
    case (command_i)
      CMD_INSERT: begin
        if (full) begin
          exec_res.status = STAT_FULL;
        end else begin
          for (int i = 1; i < DEPTH; i++) begin
            if (IDX_W'(i) > ins_p) begin
              cells_d[i] = cells_q[i-1];
            end
          end
          for (int i = 0; i < DEPTH; i++) begin
            if (IDX_W'(i) == ins_p) begin
              cells_d[i] = operand_i;
            end
          end
          count_d             = count_q + CNT_W'(1);
          exec_res.position   = POS_W'(ins_p);
          exec_res.item_value = operand_i;
        end
      end
      CMD_REMOVE, CMD_SEARCH: begin
        if (!hit) begin
          exec_res.status = STAT_NOT_FOUND;
        end else begin
          if (command_i == CMD_REMOVE) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (IDX_W'(i) >= eq_p) begin
                cells_d[i] = cells_q[i+1];
              end
            end
            count_d = count_q - CNT_W'(1);
          end
          exec_res.found      = 1'b1;
          exec_res.position   = POS_W'(eq_p);
          exec_res.item_value = operand_i;
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
        // dump of an empty store and unused codes: zero result apart from element count and last
      end
    endcase
    exec_res.element_count = NUM_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      cells_q <= cells_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q <= exec_res;
    end else if (cmd_i.emit) begin
      res_q.status        <= STAT_OK;
      res_q.found         <= 1'b0;
      res_q.position      <= POS_W'(cmd_i.idx);
      res_q.item_value    <= cells_q[cmd_i.idx];
      res_q.element_count <= NUM_W'(count_q);
      res_q.last          <= cmd_i.last;
    end
  end

  assign count_o = count_q;
  assign res_o   = res_q;

endmodule

// ===== design/sorted_value_list.sv =====
// Sorted value list top level: stream ports, controller and cell datapath.
//
// Usage: a bounded store of signed 32-bit values kept in ascending order.
// Input transactions carry a command in s_axis_tuser and an operand in
// s_axis_tdata: insert, remove, search, clear, dump ascending, dump descending.
// Each result transaction gives status, found, position, value and element
// count in m_axis_tdata; m_axis_tlast marks the final result of a command.
// Insert, remove, search and clear run in the cycle of acceptance; the result
// is registered and shows in the next cycle. One such command per cycle is
// taken while the result register is free or being drained.
// A dump of N values (N > 0) is accepted into a dump state, which then loads
// one value per cycle out of the cell array while the result register is free
// or being drained; no input is taken until its last result has been loaded.
// A dump of an empty store gives one zero result. Reset clears the element
// count and empties the result register; cell contents are left as they are
// and never read beyond the count. When the receiver stalls, the result
// register holds and s_axis_tready drops until it is taken.
module sorted_value_list (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [svl_pkg::VAL_W-1:0]         s_axis_tdata,   // [31:0] operand_value
  input  logic [svl_pkg::CMD_W-1:0]         s_axis_tuser,   // [2:0] command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] status, [2] found, [7:3] position, [39:8] item_value,
  // [45:40] element_count, [47:46] zero
  output logic [svl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast
);
  import svl_pkg::*;

  ctl_cmd_t         cmd;
  res_t             res;
  logic [CNT_W-1:0] count;

  svl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .command_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .count_i     (count),
    .cmd_o       (cmd)
  );

  svl_cells u_cells (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .command_i (s_axis_tuser),
    .operand_i ($signed(s_axis_tdata)),
    .count_o   (count),
    .res_o     (res)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, res.element_count,
                         res.item_value, res.position, res.found, res.status};
  assign m_axis_tlast = res.last;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the sorted value list: command stream in, checked results out.

class value_list_scoreboard;
  logic signed [svl_pkg::VAL_W-1:0] held[svl_pkg::DEPTH];
  int                               held_count;
  svl_pkg::res_t                    pending[$];
  int unsigned                      error_count;

  function new();
    held_count  = 0;
    error_count = 0;
  endfunction

  function void queue_result(logic [svl_pkg::STAT_W-1:0] status, logic found, int pos,
                             logic signed [svl_pkg::VAL_W-1:0] value, logic last);
    svl_pkg::res_t r;
    r.status        = status;
    r.found         = found;
    r.position      = svl_pkg::POS_W'(pos);
    r.item_value    = value;
    r.element_count = svl_pkg::NUM_W'(held_count);
    r.last          = last;
    pending.push_back(r);
  endfunction

  // Random value already in the list; caller makes sure the list is not empty.
  function logic signed [svl_pkg::VAL_W-1:0] any_held();
    return held[$urandom_range(held_count - 1)];
  endfunction

  // Work out the results of one accepted command and update the list image.
  function void note_command(logic [svl_pkg::CMD_W-1:0] cmd,
                             logic signed [svl_pkg::VAL_W-1:0] value);
    int i;
    int p;
    case (cmd)
      svl_pkg::CMD_INSERT: begin
        if (held_count >= svl_pkg::DEPTH) begin
          queue_result(svl_pkg::STAT_FULL, 1'b0, 0, '0, 1'b1);
        end else begin
          p = 0;
          while (p < held_count && held[p] < value) p++;
          for (i = held_count; i > p; i--) held[i] = held[i-1];
          held[p] = value;
          held_count++;
          queue_result(svl_pkg::STAT_OK, 1'b0, p, value, 1'b1);
        end
      end
      svl_pkg::CMD_REMOVE, svl_pkg::CMD_SEARCH: begin
        p = 0;
        while (p < held_count && held[p] != value) p++;
        if (p == held_count) begin
          queue_result(svl_pkg::STAT_NOT_FOUND, 1'b0, 0, '0, 1'b1);
        end else begin
          if (cmd == svl_pkg::CMD_REMOVE) begin
            for (i = p; i + 1 < held_count; i++) held[i] = held[i+1];
            held_count--;
          end
          queue_result(svl_pkg::STAT_OK, 1'b1, p, value, 1'b1);
        end
      end
      svl_pkg::CMD_CLEAR: begin
        held_count = 0;
        queue_result(svl_pkg::STAT_OK, 1'b0, 0, '0, 1'b1);
      end
      svl_pkg::CMD_DUMP_UP, svl_pkg::CMD_DUMP_DOWN: begin
        if (held_count == 0) queue_result(svl_pkg::STAT_OK, 1'b0, 0, '0, 1'b1);
        for (i = 0; i < held_count; i++) begin
          p = (cmd == svl_pkg::CMD_DUMP_UP) ? i : held_count - 1 - i;
          queue_result(svl_pkg::STAT_OK, 1'b0, p, held[p], i + 1 == held_count);
        end
      end
      default: begin
        queue_result(svl_pkg::STAT_OK, 1'b0, 0, '0, 1'b1);
      end
    endcase
  endfunction

  function void compare_field(string name, longint expected, longint actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expected, actual);
      error_count++;
    end
  endfunction

  function void check_result(logic [svl_pkg::OUT_TDATA_W-1:0] data, logic last);
    svl_pkg::res_t exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result, expected none, got data %0h last %0b",
               $time, data, last);
      error_count++;
      return;
    end
    exp = pending.pop_front();
    compare_field("status", exp.status, data[1:0]);
    compare_field("found", exp.found, data[2]);
    compare_field("position", exp.position, data[7:3]);
    // raw bit pattern on both sides, no sign extension
    compare_field("item_value", $unsigned(exp.item_value), data[39:8]);
    compare_field("element_count", exp.element_count, data[45:40]);
    compare_field("last", exp.last, last);
  endfunction
endclass

module tb;
  import svl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int               STALL_LIMIT = 2000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [VAL_W-1:0]       s_axis_tdata  = '0;
  logic [CMD_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  value_list_scoreboard sb = new();

  sorted_value_list i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_command(cmd, value);
  endtask

  // Extremes and a small pool, so that duplicates and hits are common.
  function automatic logic [VAL_W-1:0] random_operand();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5, 6: return VAL_W'($urandom_range(7));
      default: return $urandom();
    endcase
  endfunction

  task automatic random_command();
    int unsigned      roll;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
    roll  = $urandom_range(99);
    value = random_operand();
    if (roll < 30)      cmd = CMD_INSERT;
    else if (roll < 50) cmd = CMD_REMOVE;
    else if (roll < 70) cmd = CMD_SEARCH;
    else if (roll < 80) cmd = CMD_DUMP_UP;
    else if (roll < 90) cmd = CMD_DUMP_DOWN;
    else if (roll < 94) cmd = CMD_CLEAR;
    else if (roll < 97) cmd = CMD_SPARE_A;
    else                cmd = CMD_SPARE_B;
    if ((cmd == CMD_REMOVE || cmd == CMD_SEARCH) && sb.held_count > 0 &&
        $urandom_range(99) < 60) value = sb.any_held();
    send_command(cmd, value);
  endtask

  // Fill the list to the top, knock on it twice while full, then mix.
  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    int i;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sb.held_count < DEPTH) begin
      if ($urandom_range(9) == 0) random_command();
      else send_command(CMD_INSERT, random_operand());
    end
    send_command(CMD_INSERT, random_operand());
    send_command(CMD_INSERT, $urandom());
    for (i = 0; i < 18; i++) random_command();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, extremes, duplicates, hits and misses, spare codes
    send_command(CMD_DUMP_UP, $urandom());
    send_command(CMD_DUMP_DOWN, $urandom());
    send_command(CMD_SEARCH, 32'd5);
    send_command(CMD_REMOVE, 32'd5);
    send_command(CMD_INSERT, 32'h0000_0000);
    send_command(CMD_INSERT, 32'h7fff_ffff);
    send_command(CMD_INSERT, 32'h8000_0000);
    send_command(CMD_INSERT, 32'hffff_ffff);
    send_command(CMD_INSERT, 32'h0000_0000);
    send_command(CMD_INSERT, 32'h0000_0001);
    send_command(CMD_SEARCH, 32'h0000_0000);
    send_command(CMD_SEARCH, 32'h8000_0000);
    send_command(CMD_SEARCH, 32'h7fff_ffff);
    send_command(CMD_SEARCH, 32'h0000_0003);
    send_command(CMD_DUMP_UP, $urandom());
    send_command(CMD_DUMP_DOWN, $urandom());
    send_command(CMD_REMOVE, 32'h0000_0000);
    send_command(CMD_REMOVE, 32'hffff_ffff);
    send_command(CMD_REMOVE, 32'd123);
    send_command(CMD_SPARE_A, $urandom());
    send_command(CMD_SPARE_B, $urandom());
    send_command(CMD_DUMP_UP, $urandom());
    send_command(CMD_CLEAR, $urandom());
    send_command(CMD_DUMP_DOWN, $urandom());
    send_command(CMD_INSERT, 32'd42);

    run_phase(0, 0);
    run_phase(80, 0);
    run_phase(0, 80);
    run_phase(10, 10);
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== sorted_value_list.f =====
+incdir+design
design/svl_pkg.sv
design/svl_ctrl.sv
design/svl_cells.sv
design/sorted_value_list.sv
dv/tb.sv
